// File: hw/rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the Sampson inlier scoring core
// Item layout, sequencer states, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned MAX_MATCHES_DEF = 4096;

  localparam int unsigned PT_W     = 16;
  localparam int unsigned F_W      = 32;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned COST_W   = 48;
  localparam int unsigned U_W      = 52;   // u0..v1, signed
  localparam int unsigned NUM_W    = 68;   // epipolar residual, signed
  localparam int unsigned ACC_W    = 128;
  localparam int unsigned DEN_W    = 104;
  localparam int unsigned DIV_W    = DEN_W + 32;
  localparam int unsigned MUL_W    = 33;

  localparam int unsigned APB_AW   = 6;
  localparam int unsigned APB_DW   = 64;

  // register indexes, byte address = 8 * index
  localparam logic [2:0] REG_F_PAIR_0    = 3'd0;
  localparam logic [2:0] REG_F_PAIR_1    = 3'd1;
  localparam logic [2:0] REG_F_PAIR_2    = 3'd2;
  localparam logic [2:0] REG_F_PAIR_3    = 3'd3;
  localparam logic [2:0] REG_F_ENTRY_8   = 3'd4;
  localparam logic [2:0] REG_THRESHOLD   = 3'd5;

  localparam logic [5:0] MAC_LAST  = 6'd35;
  localparam logic [4:0] DIV_LAST  = 5'd31;

  // accumulator shift of a partial product
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_33 = 2'd2,
    SH_64 = 2'd3
  } sis_shift_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MAC  = 3'd1,
    ST_CHK  = 3'd2,
    ST_DIV  = 3'd3,
    ST_DONE = 3'd4
  } sis_state_t;

  typedef struct packed {
    logic signed [PT_W-1:0] first_x;
    logic signed [PT_W-1:0] first_y;
    logic signed [PT_W-1:0] second_x;
    logic signed [PT_W-1:0] second_y;
    logic                   last_match;
  } sis_item_t;

endpackage

// File: hw/rtl/sis_front.sv
// ----------------------------------------------------------------------------
// sis_front: input side of the scoring core
// Accepts correspondences, unpacks them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sis_front import sis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [4*PT_W-1:0]     s_tdata,
  input  logic                  s_tlast,
  output logic                  item_valid,
  input  logic                  item_ready,
  output sis_item_t             item
);

  sis_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  sis_item_t  incoming;

  always_comb begin
    incoming.first_x    = s_tdata[15:0];
    incoming.first_y    = s_tdata[31:16];
    incoming.second_x   = s_tdata[47:32];
    incoming.second_y   = s_tdata[63:48];
    incoming.last_match = s_tlast;
  end

  assign s_tready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;
  assign item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/sis_engine.sv
// ----------------------------------------------------------------------------
// sis_engine: Sampson distance sequencer and running score
// One shared 33x33 multiplier into a 128-bit accumulator, then a
// restoring divider, then the count/cost update and the result register.
// ----------------------------------------------------------------------------
module sis_engine import sis_pkg::*; #(
  parameter int unsigned MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_MATCHES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [8:0][F_W-1:0]    fmat,
  input  logic [ERR_W-1:0]       threshold,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  sis_item_t              item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_inlier,
  output logic [ERR_W-1:0]       out_err,
  output logic [CNT_W-1:0]       out_count,
  output logic [COST_W-1:0]      out_cost,
  output logic                   out_last
);

  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_MATCHES);
  localparam logic [COST_W:0]   COST_SAT = {1'b0, {COST_W{1'b1}}};

  sis_state_t state, state_next;
  logic [5:0] step;
  logic [4:0] dcnt;

  sis_item_t  cur;
  logic signed [U_W-1:0]   u0, u1, u2, v0, v1;
  logic signed [NUM_W-1:0] num;
  logic [ACC_W-1:0]        acc, acc_next, rem;
  logic [DEN_W-1:0]        den;
  logic [DIV_W-1:0]        dsh;
  logic [ERR_W-1:0]        quo;
  logic                    sat;

  logic [CNT_W-1:0]  run_cnt;
  logic [COST_W-1:0] run_cost;

  // control decode
  logic take, mac_en, chk_en, div_en, fin_en, out_free;

  // multiplier operands
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [ACC_W-1:0]          prod_ext, addend;
  sis_shift_t                sh;
  logic                      clr;

  logic [NUM_W-1:0] num_abs;
  logic [63:0]      nmag;
  logic [63:0]      mu0, mu1, mv0, mv1;

  function automatic logic signed [MUL_W-1:0] sf(input logic [F_W-1:0] v);
    return {v[F_W-1], v};
  endfunction

  function automatic logic signed [MUL_W-1:0] sp(input logic [PT_W-1:0] v);
    return {{(MUL_W-PT_W){v[PT_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_W-1:0] ulo(input logic [63:0] v);
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [MUL_W-1:0] uhi_s(input logic [U_W-1:0] v);
    return {{(MUL_W-(U_W-32)){v[U_W-1]}}, v[U_W-1:32]};
  endfunction

  function automatic logic [63:0] umag(input logic [U_W-1:0] v);
    logic [U_W-1:0] m;
    m = v[U_W-1] ? (~v + U_W'(1)) : v;
    return {{(64-U_W){1'b0}}, m};
  endfunction

  function automatic logic [63:0] sx64(input logic [U_W-1:0] v);
    return {{(64-U_W){v[U_W-1]}}, v};
  endfunction

  assign num_abs = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign nmag    = num_abs[63:0];
  assign mu0     = umag(u0);
  assign mu1     = umag(u1);
  assign mv0     = umag(v0);
  assign mv1     = umag(v1);

  // operand schedule
  always_comb begin
    op_a = '0;
    op_b = '0;
    sh   = SH_0;
    clr  = 1'b0;
    case (step)
      6'd0:  begin op_a = sf(fmat[0]); op_b = sp(cur.first_x); clr = 1'b1; end
      6'd1:  begin op_a = sf(fmat[1]); op_b = sp(cur.first_y); end
      6'd2:  begin op_a = sf(fmat[2]); op_b = 33'sd16; end
      6'd3:  begin op_a = sf(fmat[3]); op_b = sp(cur.first_x); clr = 1'b1; end
      6'd4:  begin op_a = sf(fmat[4]); op_b = sp(cur.first_y); end
      6'd5:  begin op_a = sf(fmat[5]); op_b = 33'sd16; end
      6'd6:  begin op_a = sf(fmat[6]); op_b = sp(cur.first_x); clr = 1'b1; end
      6'd7:  begin op_a = sf(fmat[7]); op_b = sp(cur.first_y); end
      6'd8:  begin op_a = sf(fmat[8]); op_b = 33'sd16; end
      6'd9:  begin op_a = sf(fmat[0]); op_b = sp(cur.second_x); clr = 1'b1; end
      6'd10: begin op_a = sf(fmat[3]); op_b = sp(cur.second_y); end
      6'd11: begin op_a = sf(fmat[6]); op_b = 33'sd16; end
      6'd12: begin op_a = sf(fmat[1]); op_b = sp(cur.second_x); clr = 1'b1; end
      6'd13: begin op_a = sf(fmat[4]); op_b = sp(cur.second_y); end
      6'd14: begin op_a = sf(fmat[7]); op_b = 33'sd16; end
      6'd15: begin op_a = ulo(sx64(u0)); op_b = sp(cur.second_x); clr = 1'b1; end
      6'd16: begin op_a = uhi_s(u0); op_b = sp(cur.second_x); sh = SH_32; end
      6'd17: begin op_a = ulo(sx64(u1)); op_b = sp(cur.second_y); end
      6'd18: begin op_a = uhi_s(u1); op_b = sp(cur.second_y); sh = SH_32; end
      6'd19: begin op_a = ulo(sx64(u2)); op_b = 33'sd16; end
      6'd20: begin op_a = uhi_s(u2); op_b = 33'sd16; sh = SH_32; end
      6'd21: begin op_a = ulo(nmag); op_b = ulo(nmag); clr = 1'b1; end
      6'd22: begin op_a = ulo(nmag); op_b = {1'b0, nmag[63:32]}; sh = SH_33; end
      6'd23: begin op_a = {1'b0, nmag[63:32]}; op_b = {1'b0, nmag[63:32]}; sh = SH_64; end
      6'd24: begin op_a = ulo(mu0); op_b = ulo(mu0); clr = 1'b1; end
      6'd25: begin op_a = ulo(mu0); op_b = {1'b0, mu0[63:32]}; sh = SH_33; end
      6'd26: begin op_a = {1'b0, mu0[63:32]}; op_b = {1'b0, mu0[63:32]}; sh = SH_64; end
      6'd27: begin op_a = ulo(mu1); op_b = ulo(mu1); end
      6'd28: begin op_a = ulo(mu1); op_b = {1'b0, mu1[63:32]}; sh = SH_33; end
      6'd29: begin op_a = {1'b0, mu1[63:32]}; op_b = {1'b0, mu1[63:32]}; sh = SH_64; end
      6'd30: begin op_a = ulo(mv0); op_b = ulo(mv0); end
      6'd31: begin op_a = ulo(mv0); op_b = {1'b0, mv0[63:32]}; sh = SH_33; end
      6'd32: begin op_a = {1'b0, mv0[63:32]}; op_b = {1'b0, mv0[63:32]}; sh = SH_64; end
      6'd33: begin op_a = ulo(mv1); op_b = ulo(mv1); end
      6'd34: begin op_a = ulo(mv1); op_b = {1'b0, mv1[63:32]}; sh = SH_33; end
      6'd35: begin op_a = {1'b0, mv1[63:32]}; op_b = {1'b0, mv1[63:32]}; sh = SH_64; end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = {{(ACC_W-2*MUL_W){prod[2*MUL_W-1]}}, prod};

  always_comb begin
    case (sh)
      SH_32:   addend = prod_ext << 32;
      SH_33:   addend = prod_ext << 33;
      SH_64:   addend = prod_ext << 64;
      default: addend = prod_ext;
    endcase
    acc_next = (clr ? '0 : acc) + addend;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_valid) state_next = ST_MAC;
      ST_MAC:  if (step == MAC_LAST) state_next = ST_CHK;
      ST_CHK:  state_next = ST_DIV;
      ST_DIV:  if (dcnt == DIV_LAST) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_ready = 1'b0;
    mac_en     = 1'b0;
    chk_en     = 1'b0;
    div_en     = 1'b0;
    fin_en     = 1'b0;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_MAC:  mac_en = 1'b1;
      ST_CHK:  chk_en = 1'b1;
      ST_DIV:  div_en = 1'b1;
      ST_DONE: fin_en = out_free;
      default: item_ready = 1'b0;
    endcase
  end

  assign take     = item_valid && item_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        step <= '0;
      end else if (mac_en) begin
        step <= step + 6'd1;
      end
      if (chk_en) begin
        dcnt <= '0;
      end else if (div_en) begin
        dcnt <= dcnt + 5'd1;
      end
    end
  end

  // datapath
  logic [DIV_W-1:0] rem_w;
  logic             ge;
  assign rem_w = {{(DIV_W-ACC_W){1'b0}}, rem};
  assign ge    = (rem_w >= dsh);

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= item;
    end
    if (mac_en) begin
      acc <= acc_next;
      case (step)
        6'd2:    u0  <= acc_next[U_W-1:0];
        6'd5:    u1  <= acc_next[U_W-1:0];
        6'd8:    u2  <= acc_next[U_W-1:0];
        6'd11:   v0  <= acc_next[U_W-1:0];
        6'd14:   v1  <= acc_next[U_W-1:0];
        6'd20:   num <= acc_next[NUM_W-1:0];
        6'd23:   rem <= acc_next;
        6'd35:   den <= acc_next[DEN_W-1:0];
        default: ;
      endcase
    end
    if (chk_en) begin
      sat <= (den == '0) || ({{(DIV_W-ACC_W){1'b0}}, rem} >= {den, 32'b0});
      dsh <= {1'b0, den, 31'b0};
      quo <= '0;
    end
    if (div_en) begin
      if (ge) begin
        rem <= rem - dsh[ACC_W-1:0];
      end
      quo <= {quo[ERR_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  // score update and result register
  logic [ERR_W-1:0]  err;
  logic              inl;
  logic [COST_W:0]   cost_sum;
  logic [COST_W-1:0] cost_new;
  logic [CNT_W-1:0]  cnt_new;

  always_comb begin
    err      = sat ? {ERR_W{1'b1}} : quo;
    inl      = (threshold > err);
    cost_sum = {1'b0, run_cost} + {{(COST_W+1-ERR_W){1'b0}}, (inl ? err : threshold)};
    cost_new = (cost_sum > COST_SAT) ? COST_SAT[COST_W-1:0] : cost_sum[COST_W-1:0];
    cnt_new  = (inl && run_cnt < CNT_MAX) ? run_cnt + CNT_W'(1) : run_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt   <= '0;
      run_cost  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_en) begin
        out_valid <= 1'b1;
        run_cnt   <= cur.last_match ? '0 : cnt_new;
        run_cost  <= cur.last_match ? '0 : cost_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      out_inlier <= inl;
      out_err    <= err;
      out_count  <= cnt_new;
      out_cost   <= cost_new;
      out_last   <= cur.last_match;
    end
  end

endmodule

// File: hw/rtl/sampson_inlier_scoring_core.sv
// ----------------------------------------------------------------------------
// sampson_inlier_scoring_core: Sampson distance inlier scoring
// Scores point correspondences against a programmed fundamental matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Program the matrix and threshold over the APB port (64-bit registers at
//   byte address 8*index) while the core is idle. Stream correspondences on
//   the s_* channel; each transaction yields one result transaction on m_*.
//   s_tlast closes a set: its result carries the final inlier count and
//   saturated cost, and both totals then clear for the next set.
// Scoring sequence:
//   Each correspondence is scored in turn: 36 multiply-accumulate steps on one
//   shared 33x33 multiplier, a range check, 32 restoring divide steps and a
//   commit step. The engine takes no new item until the last one commits;
//   a two-entry input queue takes new transactions while an item is scored.
// Reset (rst, synchronous, active high):
//   Configuration registers go to zero, queue and totals empty, no result pending.
// Stall:
//   A held result stays in m_tdata until taken; the engine waits at commit
//   and the input queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module sampson_inlier_scoring_core import sis_pkg::*; #(
  parameter int unsigned MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_MATCHES + 1),
  parameter int unsigned OUT_W       = ((ERR_W + CNT_W + COST_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [4*PT_W-1:0]    s_tdata,   // first_x, first_y, second_x, second_y
  input  logic                 s_tlast,   // last_match
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // error_sq, inlier_count, total_cost, zero pad
  output logic                 m_tuser,   // is_inlier
  output logic                 m_tlast    // set_done
);

  logic [APB_DW-1:0] f_pair [4];
  logic [F_W-1:0]    f_entry_8;
  logic [ERR_W-1:0]  inlier_threshold;
  logic [8:0][F_W-1:0] fmat;

  logic       cfg_we;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  // register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      f_pair[0]        <= '0;
      f_pair[1]        <= '0;
      f_pair[2]        <= '0;
      f_pair[3]        <= '0;
      f_entry_8        <= '0;
      inlier_threshold <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_F_PAIR_0:  f_pair[0]        <= pwdata;
        REG_F_PAIR_1:  f_pair[1]        <= pwdata;
        REG_F_PAIR_2:  f_pair[2]        <= pwdata;
        REG_F_PAIR_3:  f_pair[3]        <= pwdata;
        REG_F_ENTRY_8: f_entry_8        <= pwdata[F_W-1:0];
        REG_THRESHOLD: inlier_threshold <= pwdata[ERR_W-1:0];
        default:       f_entry_8        <= f_entry_8;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_F_PAIR_0:  prdata = f_pair[0];
      REG_F_PAIR_1:  prdata = f_pair[1];
      REG_F_PAIR_2:  prdata = f_pair[2];
      REG_F_PAIR_3:  prdata = f_pair[3];
      REG_F_ENTRY_8: prdata = {{(APB_DW-F_W){1'b0}}, f_entry_8};
      REG_THRESHOLD: prdata = {{(APB_DW-ERR_W){1'b0}}, inlier_threshold};
      default:       prdata = '0;
    endcase
  end

  // row-major matrix, lower entry of each pair in the low half
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fmat[2*k]   = f_pair[k][31:0];
      fmat[2*k+1] = f_pair[k][63:32];
    end
    fmat[8] = f_entry_8;
  end

  logic      item_valid;
  logic      item_ready;
  sis_item_t item;

  sis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  logic [ERR_W-1:0]  err;
  logic [CNT_W-1:0]  cnt;
  logic [COST_W-1:0] cost;

  sis_engine #(
    .MAX_MATCHES (MAX_MATCHES),
    .CNT_W       (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .fmat       (fmat),
    .threshold  (inlier_threshold),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_inlier (m_tuser),
    .out_err    (err),
    .out_count  (cnt),
    .out_cost   (cost),
    .out_last   (m_tlast)
  );

  // pack result fields, lowest first, zero pad to whole bytes
  assign m_tdata = {{(OUT_W-ERR_W-CNT_W-COST_W){1'b0}}, cost, cnt, err};

endmodule

// File: tb/sv/sampson_inlier_scoring_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampson_inlier_scoring_core_test: self-checking bench of the scoring core
// Programs the fundamental matrix and threshold over APB, streams point
// correspondences with random idling on both sides and compares every result
// transaction against an exact Sampson distance computed in the bench.
// ----------------------------------------------------------------------------
module sampson_inlier_scoring_core_test;
  import sis_pkg::*;

  localparam int unsigned CNT_W    = 13;
  localparam int unsigned OUT_W    = 96;
  localparam logic [47:0] COST_SAT = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned WD_LIMIT = 20000;

  typedef struct packed {
    logic             inlier;
    logic [31:0]      dsq;
    logic [CNT_W-1:0] count;
    logic [47:0]      cost;
    logic             done;
  } score_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;
  logic s_tvalid, s_tready, s_tlast;
  logic [63:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser, m_tlast;
  logic [OUT_W-1:0] m_tdata;

  sampson_inlier_scoring_core DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  // Scoring state kept by the bench
  logic [63:0] f_reg [4];
  logic [31:0] f8_reg, thresh_reg;
  logic [12:0] inl_run;
  logic [47:0] cost_run;

  sis_item_t   pending_q[$];
  score_t      score_q[$];
  int          errors, wd;
  bit          calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Exact Sampson distance, floored to Q24.8, saturated.
  function automatic logic [31:0] sampson_dist(sis_item_t it);
    logic signed [63:0] f[9];
    logic signed [63:0] x1, y1, x2, y2, u0, u1, u2, v0, v1;
    logic signed [127:0] nres;
    logic [127:0] nmag;
    logic [255:0] nsq, den, quo;
    x1 = it.first_x; y1 = it.first_y; x2 = it.second_x; y2 = it.second_y;
    for (int k = 0; k < 4; k++) begin
      f[2*k]   = $signed(f_reg[k][31:0]);
      f[2*k+1] = $signed(f_reg[k][63:32]);
    end
    f[8] = $signed(f8_reg);
    u0 = f[0]*x1 + f[1]*y1 + f[2]*16;
    u1 = f[3]*x1 + f[4]*y1 + f[5]*16;
    u2 = f[6]*x1 + f[7]*y1 + f[8]*16;
    v0 = x2*f[0] + y2*f[3] + 16*f[6];
    v1 = x2*f[1] + y2*f[4] + 16*f[7];
    nres = 128'(x2)*128'(u0) + 128'(y2)*128'(u1) + 128'(16)*128'(u2);
    nmag = nres[127] ? -nres : nres;
    nsq = 256'(nmag) * 256'(nmag);
    den = 256'(u0)*256'(u0) + 256'(u1)*256'(u1) + 256'(v0)*256'(v0) + 256'(v1)*256'(v1);
    if (den == 0) return 32'hFFFF_FFFF;
    quo = nsq / den;
    return (quo > 256'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
  endfunction

  // Advance the running totals and queue the expected result.
  function automatic void score_item(sis_item_t it);
    score_t s;
    logic [48:0] sum;
    s.dsq    = sampson_dist(it);
    s.inlier = thresh_reg > s.dsq;
    if (s.inlier && inl_run < 13'(MAX_MATCHES_DEF)) inl_run++;
    sum = cost_run + (s.inlier ? s.dsq : thresh_reg);
    cost_run = sum[48] ? COST_SAT : sum[47:0];
    s.count = inl_run;
    s.cost  = cost_run;
    s.done  = it.last_match;
    score_q = {score_q, s};
    if (it.last_match) begin
      inl_run  = '0;
      cost_run = '0;
    end
  endfunction

  // Driver: feed one pending item at a time, idle in random bursts.
  int src_gap;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        score_item(pending_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the transaction
      end else if (src_gap > 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap  <= $urandom_range(0, 10);
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        s_tvalid <= 1'b1;
        {s_tdata, s_tlast} <= {pending_q[0].second_y, pending_q[0].second_x,
                               pending_q[0].first_y, pending_q[0].first_x,
                               pending_q[0].last_match};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: take results with random stalls and check each field.
  int sink_gap;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
      wd       <= 0;
    end else begin
      wd <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : wd + 1;
      if (m_tvalid && m_tready) begin
        if (score_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", m_tdata);
        end else begin
          score_t e, a;
          e = score_q.pop_front();
          a.inlier = m_tuser;
          a.dsq    = m_tdata[31:0];
          a.count  = m_tdata[44:32];
          a.cost   = m_tdata[92:45];
          a.done   = m_tlast;
          if (a != e) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp inl=%0b d=%h n=%0d c=%h l=%0b, ",
                         "got inl=%0b d=%h n=%0d c=%h l=%0b"},
                       e.inlier, e.dsq, e.count, e.cost, e.done,
                       a.inlier, a.dsq, a.count, a.cost, a.done);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (wd >= WD_LIMIT) begin
      $display("[sampson_inlier_scoring_core] ERROR");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; mirror the register.
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 3'b000}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_F_PAIR_0:  f_reg[0] = val;
      REG_F_PAIR_1:  f_reg[1] = val;
      REG_F_PAIR_2:  f_reg[2] = val;
      REG_F_PAIR_3:  f_reg[3] = val;
      REG_F_ENTRY_8: f8_reg = val[31:0];
      REG_THRESHOLD: thresh_reg = val[31:0];
      default: ;
    endcase
  endtask

  // Wait until the stream has drained, then let the engine settle.
  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid || score_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_f(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8191)) - 4096);
      default: return 32'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  task automatic program_matrix(int mode, logic [31:0] thr);
    for (int k = 0; k < 4; k++)
      reg_write(3'(k), {rand_f(mode), rand_f(mode)});
    reg_write(REG_F_ENTRY_8, {32'd0, rand_f(mode)});
    reg_write(REG_THRESHOLD, {32'd0, thr});
  endtask

  function automatic sis_item_t rand_item(int span, bit last);
    sis_item_t it;
    it.first_x  = (span == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2*span) - span);
    it.first_y  = (span == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2*span) - span);
    it.second_x = (span == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2*span) - span);
    it.second_y = (span == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2*span) - span);
    it.last_match = last;
    return it;
  endfunction

  initial begin
    sis_item_t it;
    logic [15:0] ext[4];
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0;
    f_reg = '{default: '0}; f8_reg = '0; thresh_reg = '0;
    inl_run = '0; cost_run = '0; errors = 0; calm = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;

    // All-zero matrix: zero denominator saturates, never an inlier.
    pending_q = {pending_q, rand_item(0, 1'b0)};
    pending_q = {pending_q, rand_item(0, 1'b1)};
    drain();

    // Extreme matrix entries and point coordinates, maximum threshold.
    reg_write(REG_F_PAIR_0, 64'h7FFF_FFFF_8000_0000);
    reg_write(REG_F_PAIR_1, 64'h8000_0000_7FFF_FFFF);
    reg_write(REG_F_PAIR_2, 64'hFFFF_FFFF_0000_0001);
    reg_write(REG_F_PAIR_3, 64'h7FFF_FFFF_8000_0000);
    reg_write(REG_F_ENTRY_8, 64'h8000_0000);
    reg_write(REG_THRESHOLD, 64'hFFFF_FFFF);
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    for (int k = 0; k < 16; k++) begin
      it.first_x = ext[k % 4]; it.first_y = ext[(k / 4) % 4];
      it.second_x = ext[(k + 1) % 4]; it.second_y = ext[(k + 3) % 4];
      it.last_match = (k == 15);
      pending_q = {pending_q, it};
    end
    drain();

    // Small epipolar-like matrix: many inliers, a six-item set for cost growth.
    program_matrix(1, 32'h0000_05FE);
    for (int k = 0; k < 6; k++) pending_q = {pending_q, rand_item(200, k == 5)};
    drain();

    // Random phases over several matrix scales and thresholds.
    for (int ph = 0; ph < 8; ph++) begin
      int span;
      case (ph % 4)
        0: program_matrix(0, $urandom());
        1: program_matrix(1, $urandom_range(0, 4000));
        2: program_matrix(2, 32'hFFFF_FFFF);
        default: program_matrix(1, 32'd0);
      endcase
      calm = (ph == 7);
      for (int k = 0; k < 50; k++) begin
        span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000);
        pending_q = {pending_q,
                     rand_item(span, $urandom_range(0, 15) == 0 || k == 49)};
      end
      drain();
    end

    if (errors == 0) begin
      $display("[sampson_inlier_scoring_core] OK");
    end else begin
      $display("[sampson_inlier_scoring_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sis_pkg.sv
hw/rtl/sis_front.sv
hw/rtl/sis_engine.sv
hw/rtl/sampson_inlier_scoring_core.sv
tb/sv/sampson_inlier_scoring_core_test.sv
